// ===== design/bpc_pkg.sv =====
// package for the barometric pressure compensation block: widths, register map, reset values
package bpc_pkg;

  localparam int unsigned RawW      = 24;  // raw converter reading
  localparam int unsigned CoefW     = 16;  // calibration word
  localparam int unsigned DtW       = 25;  // temperature difference
  localparam int unsigned TempW     = 19;  // temperature in 0.01 degC
  localparam int unsigned PresW     = 32;  // pressure in 0.01 mbar
  localparam int unsigned ProdW     = 42;  // dt times calibration word
  localparam int unsigned SqW       = 36;  // squared temperature terms
  localparam int unsigned WideW     = 40;  // offset and sensitivity
  localparam int unsigned SensLoW   = 20;  // low slice of sensitivity for the split multiply
  localparam int unsigned FullW     = 64;  // full pressure product
  localparam int unsigned DiffW     = 45;  // scaled product minus offset
  localparam int unsigned NumStages = 9;

  localparam int unsigned InDataW   = 48;  // raw_pressure, raw_temp
  localparam int unsigned OutDataW  = 56;  // pressure_out, temp_out, padding
  localparam int unsigned AddrW     = 5;
  localparam int unsigned ApbDataW  = 32;

  localparam int signed TempRef    = 2000;   // 20.00 degC
  localparam int signed TempLowOff = 3500;   // distance from 20.00 down to -15.00 degC

  typedef enum logic [2:0] {
    RegSensCoef     = 3'd0,
    RegOffsetCoef   = 3'd1,
    RegSensTempco   = 3'd2,
    RegOffsetTempco = 3'd3,
    RegRefTemp      = 3'd4,
    RegTempSensCoef = 3'd5
  } reg_idx_e;

  localparam logic [CoefW-1:0] SensCoefRst     = 16'd40127;
  localparam logic [CoefW-1:0] OffsetCoefRst   = 16'd36924;
  localparam logic [CoefW-1:0] SensTempcoRst   = 16'd23317;
  localparam logic [CoefW-1:0] OffsetTempcoRst = 16'd23282;
  localparam logic [CoefW-1:0] RefTempRst      = 16'd33464;
  localparam logic [CoefW-1:0] TempSensCoefRst = 16'd28312;

endpackage

// ===== design/baro_pressure_compensation.sv =====
// top level: nine-stage pipeline for second-order barometric pressure compensation
//
//  channel   | direction | fields (lowest bit first)          | handshake
//  ----------+-----------+------------------------------------+-----------------------
//  s_axis    | in        | raw_pressure[23:0], raw_temp[47:24] | tvalid / tready
//  m_axis    | out       | pressure_out[31:0], temp_out[50:32] | tvalid / tready
//  apb       | in        | six 16-bit calibration words        | psel / penable / pwrite
//
//  nine register stages: an accepted item moves through stages 1 to 9 in order and
//  leaves from the stage 9 register; one item per cycle sustained unless m_axis stalls
//  the stage count is set by the multipliers: dt products, the squares and the split
//  24 x 40 pressure product, each followed by a register
//  every stage has its own valid bit and loads when it is empty or its successor moves,
//  so bubbles are squeezed out and the input stalls only when all nine stages are full
//  and the output is stalled
//  reset clears the valid bits and loads the calibration words with their factory values;
//  there is no clearing pass, the block is ready in the first cycle after reset
module baro_pressure_compensation (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input items
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [bpc_pkg::InDataW-1:0]     s_axis_tdata,   // raw_pressure, raw_temp
  // result items
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [bpc_pkg::OutDataW-1:0]    m_axis_tdata,   // pressure_out, temp_out, zero pad
  // calibration registers
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bpc_pkg::AddrW-1:0]       paddr,
  input  logic [bpc_pkg::ApbDataW-1:0]    pwdata,
  output logic [bpc_pkg::ApbDataW-1:0]    prdata,
  output logic                            pready
);
  import bpc_pkg::*;

  // ---------------------------------------------------------------------------
  // calibration registers
  // ---------------------------------------------------------------------------
  logic [CoefW-1:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;
  logic             cfg_wr;
  reg_idx_e         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[AddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= SensCoefRst;
      c2_q <= OffsetCoefRst;
      c3_q <= SensTempcoRst;
      c4_q <= OffsetTempcoRst;
      c5_q <= RefTempRst;
      c6_q <= TempSensCoefRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegSensCoef:     c1_q <= pwdata[CoefW-1:0];
        RegOffsetCoef:   c2_q <= pwdata[CoefW-1:0];
        RegSensTempco:   c3_q <= pwdata[CoefW-1:0];
        RegOffsetTempco: c4_q <= pwdata[CoefW-1:0];
        RegRefTemp:      c5_q <= pwdata[CoefW-1:0];
        RegTempSensCoef: c6_q <= pwdata[CoefW-1:0];
        default: ;  // addresses past the map are ignored
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegSensCoef:     prdata = ApbDataW'(c1_q);
      RegOffsetCoef:   prdata = ApbDataW'(c2_q);
      RegSensTempco:   prdata = ApbDataW'(c3_q);
      RegOffsetTempco: prdata = ApbDataW'(c4_q);
      RegRefTemp:      prdata = ApbDataW'(c5_q);
      RegTempSensCoef: prdata = ApbDataW'(c6_q);
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // flow control: stage k loads when it is empty or stage k+1 takes its item
  // ---------------------------------------------------------------------------
  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] vld_d;
  logic [NumStages:0]   rdy;   // rdy[NumStages] is the downstream ready

  always_comb begin
    rdy[NumStages] = m_axis_tready;
    for (int k = NumStages - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    vld_d[0] = rdy[0] ? s_axis_tvalid : vld_q[0];
    for (int k = 1; k < NumStages; k++) begin
      vld_d[k] = rdy[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld_q[NumStages-1];

  // ---------------------------------------------------------------------------
  // stage 1: dt = D2 - C5*256
  // ---------------------------------------------------------------------------
  logic [RawW-1:0]        s1_d1_q;
  logic signed [DtW-1:0]  s1_dt_q;
  logic signed [DtW-1:0]  s1_dt_d;

  assign s1_dt_d = $signed({1'b0, s_axis_tdata[2*RawW-1:RawW]})
                 - $signed({1'b0, c5_q, 8'd0});

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s1_d1_q <= s_axis_tdata[RawW-1:0];
      s1_dt_q <= s1_dt_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: the three dt products, one multiplier each
  // ---------------------------------------------------------------------------
  logic [RawW-1:0]          s2_d1_q;
  logic signed [ProdW-1:0]  s2_ptemp_q, s2_poff_q, s2_psens_q;
  logic signed [ProdW-1:0]  s2_ptemp_d, s2_poff_d, s2_psens_d;
  logic signed [CoefW:0]    c3_s, c4_s, c6_s;

  assign c3_s = $signed({1'b0, c3_q});
  assign c4_s = $signed({1'b0, c4_q});
  assign c6_s = $signed({1'b0, c6_q});

  assign s2_ptemp_d = s1_dt_q * c6_s;
  assign s2_poff_d  = s1_dt_q * c4_s;
  assign s2_psens_d = s1_dt_q * c3_s;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      s2_d1_q    <= s1_d1_q;
      s2_ptemp_q <= s2_ptemp_d;
      s2_poff_q  <= s2_poff_d;
      s2_psens_q <= s2_psens_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: temperature, first-order offset and sensitivity, range flags
  // ---------------------------------------------------------------------------
  logic [RawW-1:0]          s3_d1_q;
  logic signed [TempW-1:0]  s3_tdiff_q, s3_te_q, s3_temp_q;
  logic signed [WideW-1:0]  s3_off_q, s3_sens_q;
  logic                     s3_lt_q, s3_lt2_q;
  logic signed [TempW-1:0]  s3_tdiff_d, s3_te_d, s3_temp_d;
  logic signed [WideW-1:0]  s3_off_d, s3_sens_d;

  // tdiff = TEMP - 2000, te = TEMP + 1500
  assign s3_tdiff_d = TempW'(s2_ptemp_q >>> 23);
  assign s3_temp_d  = s3_tdiff_d + TempW'(TempRef);
  assign s3_te_d    = s3_tdiff_d + TempW'(TempLowOff);
  assign s3_off_d   = $signed({8'd0, c2_q, 16'd0}) + WideW'(s2_poff_q >>> 7);
  assign s3_sens_d  = $signed({9'd0, c1_q, 15'd0}) + WideW'(s2_psens_q >>> 8);

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      s3_d1_q    <= s2_d1_q;
      s3_tdiff_q <= s3_tdiff_d;
      s3_te_q    <= s3_te_d;
      s3_temp_q  <= s3_temp_d;
      s3_off_q   <= s3_off_d;
      s3_sens_q  <= s3_sens_d;
      s3_lt_q    <= s3_tdiff_d[TempW-1];                  // below 20.00 degC
      s3_lt2_q   <= s3_tdiff_d < -TempW'(TempLowOff);     // below -15.00 degC
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: squares of the two temperature distances
  // ---------------------------------------------------------------------------
  logic [RawW-1:0]          s4_d1_q;
  logic signed [TempW-1:0]  s4_temp_q;
  logic signed [WideW-1:0]  s4_off_q, s4_sens_q;
  logic                     s4_lt_q, s4_lt2_q;
  logic [SqW-1:0]           s4_sq1_q, s4_sq2_q;
  logic signed [2*TempW-1:0] s4_sq1_d, s4_sq2_d;

  assign s4_sq1_d = s3_tdiff_q * s3_tdiff_q;
  assign s4_sq2_d = s3_te_q * s3_te_q;

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      s4_d1_q   <= s3_d1_q;
      s4_temp_q <= s3_temp_q;
      s4_off_q  <= s3_off_q;
      s4_sens_q <= s3_sens_q;
      s4_lt_q   <= s3_lt_q;
      s4_lt2_q  <= s3_lt2_q;
      s4_sq1_q  <= s4_sq1_d[SqW-1:0];
      s4_sq2_q  <= s4_sq2_d[SqW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: second-order corrections, constant multiplies as shift and add
  // ---------------------------------------------------------------------------
  logic [RawW-1:0]          s5_d1_q;
  logic signed [TempW-1:0]  s5_temp_q;
  logic signed [WideW-1:0]  s5_off_q, s5_sens_q;
  logic [WideW-1:0]         s5_coff_q, s5_csens_q;
  logic [WideW-1:0]         sq1_w, sq2_w, d5, e7, e11;
  logic [WideW-1:0]         s5_coff_d, s5_csens_d;

  assign sq1_w = WideW'(s4_sq1_q);
  assign sq2_w = WideW'(s4_sq2_q);
  assign d5    = (sq1_w << 2) + sq1_w;
  assign e7    = (sq2_w << 3) - sq2_w;
  assign e11   = (sq2_w << 3) + (sq2_w << 1) + sq2_w;

  assign s5_coff_d  = (s4_lt_q  ? (d5 >> 1)  : '0) + (s4_lt2_q ? e7 : '0);
  assign s5_csens_d = (s4_lt_q  ? (d5 >> 2)  : '0) + (s4_lt2_q ? (e11 >> 1) : '0);

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      s5_d1_q    <= s4_d1_q;
      s5_temp_q  <= s4_temp_q;
      s5_off_q   <= s4_off_q;
      s5_sens_q  <= s4_sens_q;
      s5_coff_q  <= s5_coff_d;
      s5_csens_q <= s5_csens_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 6: apply corrections
  // ---------------------------------------------------------------------------
  logic [RawW-1:0]          s6_d1_q;
  logic signed [TempW-1:0]  s6_temp_q;
  logic signed [WideW-1:0]  s6_off_q, s6_sens_q;

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      s6_d1_q   <= s5_d1_q;
      s6_temp_q <= s5_temp_q;
      s6_off_q  <= s5_off_q - $signed(s5_coff_q);
      s6_sens_q <= s5_sens_q - $signed(s5_csens_q);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 7: D1 * SENS as two partial products
  // ---------------------------------------------------------------------------
  logic signed [TempW-1:0]            s7_temp_q;
  logic signed [WideW-1:0]            s7_off_q;
  logic [RawW+SensLoW-1:0]            s7_plo_q;
  logic signed [RawW+WideW-SensLoW:0] s7_phi_q;
  logic signed [WideW-SensLoW-1:0]    sens_hi;

  assign sens_hi = s6_sens_q[WideW-1:SensLoW];

  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      s7_temp_q <= s6_temp_q;
      s7_off_q  <= s6_off_q;
      s7_plo_q  <= s6_d1_q * s6_sens_q[SensLoW-1:0];
      s7_phi_q  <= $signed({1'b0, s6_d1_q}) * sens_hi;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 8: recombine the product
  // ---------------------------------------------------------------------------
  logic signed [TempW-1:0] s8_temp_q;
  logic signed [WideW-1:0] s8_off_q;
  logic signed [FullW-1:0] s8_prod_q;
  logic signed [FullW-1:0] s8_prod_d;

  assign s8_prod_d = (FullW'(s7_phi_q) <<< SensLoW)
                   + $signed({{(FullW-RawW-SensLoW){1'b0}}, s7_plo_q});

  always_ff @(posedge clk_i) begin
    if (rdy[7]) begin
      s8_temp_q <= s7_temp_q;
      s8_off_q  <= s7_off_q;
      s8_prod_q <= s8_prod_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 9: output register, P = ((D1*SENS >> 21) - OFF) >> 15
  // ---------------------------------------------------------------------------
  logic signed [TempW-1:0] s9_temp_q;
  logic signed [PresW-1:0] s9_pres_q;
  logic signed [DiffW-1:0] s9_diff;

  assign s9_diff = DiffW'(s8_prod_q >>> 21) - DiffW'(s8_off_q);

  always_ff @(posedge clk_i) begin
    if (rdy[8]) begin
      s9_temp_q <= s8_temp_q;
      s9_pres_q <= PresW'(s9_diff >>> 15);
    end
  end

  assign m_axis_tdata = {{(OutDataW-PresW-TempW){1'b0}}, s9_temp_q, s9_pres_q};

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (&vld_q))
    else $error("input stalled while a pipeline stage is empty");

  a_accept_fills_stage1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> vld_q[0])
    else $error("accepted item did not reach the first stage");

  a_cold_implies_cool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[2] && s3_lt2_q) |-> s3_lt_q)
    else $error("below -15 degC flag without below 20 degC flag");

  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] |-> (s3_temp_q >= -TempW'(140000) && s3_temp_q <= TempW'(140000)))
    else $error("temperature outside its range");

  a_stalled_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[4] && !rdy[4]) |=> (vld_q[4] && $stable(s5_coff_q)))
    else $error("stalled stage lost or changed its item");

endmodule
